### src/stt_pkg.sv
// Shared types, codes and character helpers for the source text tokenizer.
package stt_pkg;

  localparam int LEN_W  = 24;
  localparam int LINE_W = 20;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_SLASH   = 4'd2;
  localparam logic [3:0] M_EQ      = 4'd3;
  localparam logic [3:0] M_QUEST   = 4'd4;
  localparam logic [3:0] M_BANG    = 4'd5;
  localparam logic [3:0] M_LESS    = 4'd6;
  localparam logic [3:0] M_GREATER = 4'd7;
  localparam logic [3:0] M_IDENT   = 4'd8;
  localparam logic [3:0] M_INT     = 4'd9;
  localparam logic [3:0] M_DOT     = 4'd10;
  localparam logic [3:0] M_FRAC    = 4'd11;
  localparam logic [3:0] M_STR     = 4'd12;
  localparam logic [3:0] M_STR_ESC = 4'd13;

  // token kinds
  localparam logic [4:0] K_LPAREN  = 5'd0;
  localparam logic [4:0] K_RPAREN  = 5'd1;
  localparam logic [4:0] K_COMMA   = 5'd2;
  localparam logic [4:0] K_DOT     = 5'd3;
  localparam logic [4:0] K_PERCENT = 5'd4;
  localparam logic [4:0] K_PLUS    = 5'd5;
  localparam logic [4:0] K_MINUS   = 5'd6;
  localparam logic [4:0] K_STAR    = 5'd7;
  localparam logic [4:0] K_SLASH   = 5'd8;
  localparam logic [4:0] K_CARET   = 5'd9;
  localparam logic [4:0] K_COLON   = 5'd10;
  localparam logic [4:0] K_ASSIGN  = 5'd11;
  localparam logic [4:0] K_ARROW   = 5'd12;
  localparam logic [4:0] K_QUEST   = 5'd14;
  localparam logic [4:0] K_BANG    = 5'd16;
  localparam logic [4:0] K_LESS    = 5'd18;
  localparam logic [4:0] K_GREATER = 5'd20;
  localparam logic [4:0] K_AND     = 5'd21;
  localparam logic [4:0] K_IF      = 5'd22;
  localparam logic [4:0] K_OR      = 5'd23;
  localparam logic [4:0] K_WHILE   = 5'd24;
  localparam logic [4:0] K_FALSE   = 5'd25;
  localparam logic [4:0] K_TRUE    = 5'd26;
  localparam logic [4:0] K_IDENT   = 5'd27;
  localparam logic [4:0] K_NUMBER  = 5'd28;
  localparam logic [4:0] K_STRING  = 5'd29;
  localparam logic [4:0] K_ERROR   = 5'd30;
  localparam logic [4:0] K_EOF     = 5'd31;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_UNEXPECT = 2'd1;
  localparam logic [1:0] E_UNTERM   = 2'd2;

  // keyword spellings
  localparam logic [39:0] KW_AND   = 40'h616E64;
  localparam logic [39:0] KW_IF    = 40'h6966;
  localparam logic [39:0] KW_OR    = 40'h6F72;
  localparam logic [39:0] KW_WHILE = 40'h7768696C65;
  localparam logic [39:0] KW_FALSE = 40'h66616C7365;
  localparam logic [39:0] KW_TRUE  = 40'h74727565;

  typedef struct packed {
    logic [4:0]        kind;
    logic [1:0]        err;
    logic [LEN_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
  } tok_t;

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [4:0] op_single(input logic [3:0] m);
    logic [4:0] k;
    unique case (m)
      M_SLASH: k = K_SLASH;
      M_EQ:    k = K_ASSIGN;
      M_QUEST: k = K_QUEST;
      M_BANG:  k = K_BANG;
      M_LESS:  k = K_LESS;
      default: k = K_GREATER;
    endcase
    return k;
  endfunction

endpackage

### src/stt_in_if.sv
// Byte channel into the tokenizer.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;
  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

### src/stt_out_if.sv
// Token channel out of the tokenizer.
interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [1:0]  error_kind;
  logic [23:0] token_offset;
  logic [23:0] token_length;
  logic [19:0] line_number;
  logic        last_of_run;
  modport source (output valid, token_kind, error_kind, token_offset, token_length,
                  line_number, last_of_run, input ready);
  modport sink (input valid, token_kind, error_kind, token_offset, token_length,
                line_number, last_of_run, output ready);
endinterface

### src/source_text_tokenizer_top.sv
// Streaming tokenizer: one source byte per beat in, tokens out through a queue.
//
//  channel    dir  beat
//  byte_in    in   source_byte, end_of_source
//  token_out  out  token_kind, error_kind, token_offset, token_length,
//                  line_number, last_of_run
//
// One byte is scanned per cycle while the queue has room; its up to three tokens go into
// an 8-entry queue at the accepting edge and leave from the next cycle on, one per
// cycle while the sink is ready. A byte is taken whenever the queue has room for three
// tokens, so bytes flow every cycle while tokens drain at least as fast as they are made.
// Synchronous reset returns to idle, offset 0, line 1 and empties the queue.
module source_text_tokenizer_top
  import stt_pkg::*;
#(
  parameter int POS_BITS  = 24,
  parameter int LINE_BITS = 20
) (
  input  logic            clk,
  input  logic            rst,
  stt_in_if.sink          byte_in,
  stt_out_if.source       token_out
);

  localparam int SW    = (POS_BITS + 1 > LEN_W) ? POS_BITS + 1 : LEN_W;
  localparam int DEPTH = 8;

  typedef struct packed {
    tok_t tok;
    logic last;
  } qent_t;

  logic [3:0]           scan_mode, mode_next;
  logic [POS_BITS-1:0]  position, pos_next;
  logic [POS_BITS-1:0]  token_start, ts_next;
  logic [LINE_BITS-1:0] line_count, line_next;
  logic [39:0]          name_prefix, prefix_next;

  qent_t      queue [DEPTH];
  logic [2:0] wr_ptr, rd_ptr;
  logic [3:0] fill;

  tok_t       res [3];
  logic [1:0] n;

  logic       accept, pop;
  logic [7:0] c;
  logic       fin;

  assign accept = byte_in.valid && byte_in.ready;
  assign pop    = token_out.valid && token_out.ready;
  assign byte_in.ready = fill <= 4'(DEPTH - 3);
  assign c   = byte_in.source_byte;
  assign fin = byte_in.end_of_source || c == 8'd0;

  function automatic logic [LEN_W-1:0] span(input logic [SW-1:0] from,
                                            input logic [SW-1:0] upto);
    logic [SW-1:0] d;
    d = (upto > from) ? upto - from : '0;
    return (d > SW'(LEN_MAX)) ? LEN_MAX : d[LEN_W-1:0];
  endfunction

  function automatic tok_t mk(input logic [4:0] k, input logic [1:0] e,
                              input logic [SW-1:0] off, input logic [LEN_W-1:0] len,
                              input logic [LINE_BITS-1:0] ln);
    tok_t t;
    t.kind = k;
    t.err  = e;
    t.off  = off[LEN_W-1:0];
    t.len  = len;
    t.line = LINE_W'(ln);
    return t;
  endfunction

  logic [SW-1:0]      pos_w, ts_w, pos1_w, dot_w;
  logic [LEN_W-1:0]   cur_len;
  logic [4:0]         name_kind;
  logic               line_inc, fresh;

  always_comb begin
    pos_w   = SW'(position);
    ts_w    = SW'(token_start);
    pos1_w  = pos_w + SW'(1);
    dot_w   = (position != '0) ? pos_w - SW'(1) : '0;
    cur_len = span(ts_w, pos_w);
    priority if (cur_len == 24'd3 && name_prefix == KW_AND) name_kind = K_AND;
    else if (cur_len == 24'd2 && name_prefix == KW_IF) name_kind = K_IF;
    else if (cur_len == 24'd2 && name_prefix == KW_OR) name_kind = K_OR;
    else if (cur_len == 24'd5 && name_prefix == KW_WHILE) name_kind = K_WHILE;
    else if (cur_len == 24'd5 && name_prefix == KW_FALSE) name_kind = K_FALSE;
    else if (cur_len == 24'd4 && name_prefix == KW_TRUE) name_kind = K_TRUE;
    else name_kind = K_IDENT;
  end

  always_comb begin
    mode_next   = scan_mode;
    pos_next    = position;
    ts_next     = token_start;
    line_next   = line_count;
    prefix_next = name_prefix;
    line_inc    = 1'b0;
    fresh       = 1'b0;
    n           = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    if (fin) begin
      unique case (scan_mode)
        M_SLASH, M_EQ, M_QUEST, M_BANG, M_LESS, M_GREATER: begin
          res[n] = mk(op_single(scan_mode), E_NONE, ts_w, 24'd1, line_count);
          n = n + 2'd1;
        end
        M_IDENT: begin
          res[n] = mk(name_kind, E_NONE, ts_w, cur_len, line_count);
          n = n + 2'd1;
        end
        M_INT, M_FRAC: begin
          res[n] = mk(K_NUMBER, E_NONE, ts_w, cur_len, line_count);
          n = n + 2'd1;
        end
        M_DOT: begin
          res[n] = mk(K_NUMBER, E_NONE, ts_w, span(ts_w, dot_w), line_count);
          n = n + 2'd1;
          res[n] = mk(K_DOT, E_NONE, dot_w, 24'd1, line_count);
          n = n + 2'd1;
        end
        M_STR, M_STR_ESC: begin
          res[n] = mk(K_ERROR, E_UNTERM, ts_w, cur_len, line_count);
          n = n + 2'd1;
        end
        default: ;
      endcase
      res[n] = mk(K_EOF, E_NONE, pos_w, 24'd0, line_count);
      n = n + 2'd1;
      mode_next   = M_IDLE;
      pos_next    = '0;
      ts_next     = '0;
      line_next   = LINE_BITS'(1);
      prefix_next = '0;
    end else begin
      unique case (scan_mode)
        M_COMMENT: begin
          if (c == "\n") begin
            line_inc  = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_SLASH: begin
          if (c == "/") mode_next = M_COMMENT;
          else begin
            res[n] = mk(K_SLASH, E_NONE, ts_w, 24'd1, line_count);
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        M_EQ: begin
          if (c == ">") begin
            res[n] = mk(K_ARROW, E_NONE, ts_w, span(ts_w, pos1_w), line_count);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            res[n] = mk(K_ASSIGN, E_NONE, ts_w, 24'd1, line_count);
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        M_QUEST, M_BANG, M_LESS, M_GREATER: begin
          if (c == "=") begin
            res[n] = mk(op_single(scan_mode) - 5'd1, E_NONE, ts_w, span(ts_w, pos1_w),
                        line_count);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            res[n] = mk(op_single(scan_mode), E_NONE, ts_w, 24'd1, line_count);
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        M_IDENT: begin
          if (alpha_char(c) || digit_char(c)) begin
            // keep only the first five bytes; longer names are never keywords
            if (cur_len < 24'd5) prefix_next = {name_prefix[31:0], c};
            else prefix_next = '0;
          end else begin
            res[n] = mk(name_kind, E_NONE, ts_w, cur_len, line_count);
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        M_INT: begin
          if (c == ".") mode_next = M_DOT;
          else if (!digit_char(c)) begin
            res[n] = mk(K_NUMBER, E_NONE, ts_w, cur_len, line_count);
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        M_DOT: begin
          if (digit_char(c)) mode_next = M_FRAC;
          else begin
            res[n] = mk(K_NUMBER, E_NONE, ts_w, span(ts_w, dot_w), line_count);
            n = n + 2'd1;
            res[n] = mk(K_DOT, E_NONE, dot_w, 24'd1, line_count);
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        M_FRAC: begin
          if (!digit_char(c)) begin
            res[n] = mk(K_NUMBER, E_NONE, ts_w, cur_len, line_count);
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        M_STR, M_STR_ESC: begin
          if (scan_mode == M_STR_ESC &&
              (c == "\\" || c == "'" || c == "\r" || c == "\n" || c == "\t")) begin
            mode_next = M_STR;
          end else begin
            mode_next = M_STR;
            if (c == "'") begin
              res[n] = mk(K_STRING, E_NONE, ts_w, span(ts_w, pos1_w), line_count);
              n = n + 2'd1;
              mode_next = M_IDLE;
            end else if (c == "\\") begin
              mode_next = M_STR_ESC;
            end else if (c == "\n") begin
              line_inc = 1'b1;
            end
          end
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        mode_next = M_IDLE;
        ts_next   = position;
        if (c == " " || c == "\r" || c == "\t") begin
        end else if (c == "\n") begin
          line_inc = 1'b1;
        end else if (digit_char(c)) begin
          mode_next = M_INT;
        end else if (alpha_char(c)) begin
          mode_next   = M_IDENT;
          prefix_next = 40'(c);
        end else begin
          unique case (c)
            "(": res[n] = mk(K_LPAREN, E_NONE, pos_w, 24'd1, line_count);
            ")": res[n] = mk(K_RPAREN, E_NONE, pos_w, 24'd1, line_count);
            ",": res[n] = mk(K_COMMA, E_NONE, pos_w, 24'd1, line_count);
            ".": res[n] = mk(K_DOT, E_NONE, pos_w, 24'd1, line_count);
            "%": res[n] = mk(K_PERCENT, E_NONE, pos_w, 24'd1, line_count);
            "+": res[n] = mk(K_PLUS, E_NONE, pos_w, 24'd1, line_count);
            "-": res[n] = mk(K_MINUS, E_NONE, pos_w, 24'd1, line_count);
            "*": res[n] = mk(K_STAR, E_NONE, pos_w, 24'd1, line_count);
            "^": res[n] = mk(K_CARET, E_NONE, pos_w, 24'd1, line_count);
            ":": res[n] = mk(K_COLON, E_NONE, pos_w, 24'd1, line_count);
            "/": mode_next = M_SLASH;
            "=": mode_next = M_EQ;
            "?": mode_next = M_QUEST;
            "!": mode_next = M_BANG;
            "<": mode_next = M_LESS;
            ">": mode_next = M_GREATER;
            "'": mode_next = M_STR;
            default: res[n] = mk(K_ERROR, E_UNEXPECT, pos_w, 24'd1, line_count);
          endcase
          if (mode_next == M_IDLE) n = n + 2'd1;
        end
      end

      if (line_inc && line_count != '1) line_next = line_count + LINE_BITS'(1);
      if (position != '1) pos_next = position + POS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= M_IDLE;
      position    <= '0;
      token_start <= '0;
      line_count  <= LINE_BITS'(1);
      name_prefix <= '0;
    end else if (accept) begin
      scan_mode   <= mode_next;
      position    <= pos_next;
      token_start <= ts_next;
      line_count  <= line_next;
      name_prefix <= prefix_next;
    end
  end

  // push the beat's tokens, flag the final one
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n) queue[wr_ptr + 3'(i)] <= '{tok: res[i], last: (2'(i) == n - 2'd1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + 3'(n);
      if (pop) rd_ptr <= rd_ptr + 3'd1;
      fill <= fill + (accept ? 4'(n) : 4'd0) - (pop ? 4'd1 : 4'd0);
    end
  end

  assign token_out.valid        = fill != 4'd0;
  assign token_out.token_kind   = queue[rd_ptr].tok.kind;
  assign token_out.error_kind   = queue[rd_ptr].tok.err;
  assign token_out.token_offset = queue[rd_ptr].tok.off;
  assign token_out.token_length = queue[rd_ptr].tok.len;
  assign token_out.line_number  = queue[rd_ptr].tok.line;
  assign token_out.last_of_run  = queue[rd_ptr].last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 4'(DEPTH))
    else $error("token queue overflow");
  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
      accept && byte_in.end_of_source |=> position == '0 && line_count == LINE_BITS'(1))
    else $error("end of source did not restart scanner");
  a_eof_len: assert property (@(posedge clk) disable iff (rst)
      token_out.valid && token_out.token_kind == K_EOF |-> token_out.token_length == '0)
    else $error("EOF token with nonzero length");
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
      token_out.valid && token_out.error_kind != E_NONE |-> token_out.token_kind == K_ERROR)
    else $error("error code on non-error token");

endmodule

### verif/source_text_tokenizer_top_test.sv
// Self-checking testbench for the source text tokenizer: directed and random byte streams against a predictor.
module source_text_tokenizer_top_test
  import stt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       fin;
  } src_beat_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  err;
    logic [23:0] off;
    logic [23:0] len;
    logic [19:0] line;
    logic        last;
  } token_t;

  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stt_in_if  byte_in ();
  stt_out_if token_out ();

  source_text_tokenizer_top dut (
    .clk(clk), .rst(rst), .byte_in(byte_in), .token_out(token_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scanner state mirrored from the block
  logic [3:0]  sc_mode;
  logic [23:0] sc_pos;
  logic [23:0] sc_start;
  logic [19:0] sc_line;
  logic [39:0] sc_prefix;

  src_beat_t pending_beats[$];
  token_t    expected_tokens[$];
  token_t    step_tokens[$];
  int        mismatches = 0;
  int        token_count = 0;
  int        byte_count = 0;
  longint    cycles = 0;
  bit        hold_sink = 0;

  function automatic logic [23:0] span(logic [23:0] from, logic [24:0] to);
    logic [24:0] d;
    d = (to > {1'b0, from}) ? to - {1'b0, from} : 25'd0;
    return (d > 25'hFFFFFF) ? 24'hFFFFFF : d[23:0];
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  task automatic push_token(logic [4:0] k, logic [1:0] e, logic [23:0] o, logic [23:0] l);
    token_t t;
    t = '{kind: k, err: e, off: o, len: l, line: sc_line, last: 1'b0};
    if (step_tokens.size() < 3) step_tokens.push_back(t);
  endtask

  function automatic logic [4:0] single_op(logic [3:0] m);
    case (m)
      M_SLASH: return K_SLASH;
      M_EQ:    return K_ASSIGN;
      M_QUEST: return K_QUEST;
      M_BANG:  return K_BANG;
      M_LESS:  return K_LESS;
      default: return K_GREATER;
    endcase
  endfunction

  task automatic bump_line();
    if (sc_line != 20'hFFFFF) sc_line++;
  endtask

  task automatic name_token();
    logic [23:0] l;
    logic [4:0]  k;
    l = span(sc_start, {1'b0, sc_pos});
    k = K_IDENT;
    if (l == 3 && sc_prefix == KW_AND) k = K_AND;
    else if (l == 2 && sc_prefix == KW_IF) k = K_IF;
    else if (l == 2 && sc_prefix == KW_OR) k = K_OR;
    else if (l == 5 && sc_prefix == KW_WHILE) k = K_WHILE;
    else if (l == 5 && sc_prefix == KW_FALSE) k = K_FALSE;
    else if (l == 4 && sc_prefix == KW_TRUE) k = K_TRUE;
    push_token(k, E_NONE, sc_start, l);
  endtask

  task automatic number_dot_tokens();
    logic [23:0] d;
    d = sc_pos > 0 ? sc_pos - 24'd1 : 24'd0;
    push_token(K_NUMBER, E_NONE, sc_start, span(sc_start, {1'b0, d}));
    push_token(K_DOT, E_NONE, d, 24'd1);
  endtask

  task automatic string_char(logic [7:0] c);
    sc_mode = M_STR;
    if (c == 8'h27) begin
      push_token(K_STRING, E_NONE, sc_start, span(sc_start, {1'b0, sc_pos} + 25'd1));
      sc_mode = M_IDLE;
    end else if (c == 8'h5c) begin
      sc_mode = M_STR_ESC;
    end else if (c == 8'h0a) begin
      bump_line();
    end
  endtask

  task automatic begin_token(logic [7:0] c);
    sc_mode = M_IDLE;
    sc_start = sc_pos;
    if (c == 8'h20 || c == 8'h0d || c == 8'h09) return;
    if (c == 8'h0a) begin
      bump_line();
      return;
    end
    if (digit_c(c)) begin
      sc_mode = M_INT;
      return;
    end
    if (alpha_c(c)) begin
      sc_mode = M_IDENT;
      sc_prefix = {32'd0, c};
      return;
    end
    case (c)
      "(": push_token(K_LPAREN, E_NONE, sc_pos, 24'd1);
      ")": push_token(K_RPAREN, E_NONE, sc_pos, 24'd1);
      ",": push_token(K_COMMA, E_NONE, sc_pos, 24'd1);
      ".": push_token(K_DOT, E_NONE, sc_pos, 24'd1);
      "%": push_token(K_PERCENT, E_NONE, sc_pos, 24'd1);
      "+": push_token(K_PLUS, E_NONE, sc_pos, 24'd1);
      "-": push_token(K_MINUS, E_NONE, sc_pos, 24'd1);
      "*": push_token(K_STAR, E_NONE, sc_pos, 24'd1);
      "^": push_token(K_CARET, E_NONE, sc_pos, 24'd1);
      ":": push_token(K_COLON, E_NONE, sc_pos, 24'd1);
      "/": sc_mode = M_SLASH;
      "=": sc_mode = M_EQ;
      "?": sc_mode = M_QUEST;
      "!": sc_mode = M_BANG;
      "<": sc_mode = M_LESS;
      ">": sc_mode = M_GREATER;
      8'h27: sc_mode = M_STR;
      default: push_token(K_ERROR, E_UNEXPECT, sc_pos, 24'd1);
    endcase
  endtask

  task automatic scanner_reset();
    sc_mode = M_IDLE;
    sc_pos = '0;
    sc_start = '0;
    sc_line = 20'd1;
    sc_prefix = '0;
  endtask

  // work out the tokens one source beat produces and queue them
  task automatic predict_tokens(src_beat_t b);
    logic [7:0] c;
    bit fresh;
    c = b.byte_val;
    fresh = 0;
    step_tokens.delete();
    if (b.fin || c == 8'h00) begin
      case (sc_mode)
        M_SLASH, M_EQ, M_QUEST, M_BANG, M_LESS, M_GREATER:
          push_token(single_op(sc_mode), E_NONE, sc_start, 24'd1);
        M_IDENT: name_token();
        M_INT, M_FRAC: push_token(K_NUMBER, E_NONE, sc_start, span(sc_start, {1'b0, sc_pos}));
        M_DOT: number_dot_tokens();
        M_STR, M_STR_ESC:
          push_token(K_ERROR, E_UNTERM, sc_start, span(sc_start, {1'b0, sc_pos}));
        default: ;
      endcase
      push_token(K_EOF, E_NONE, sc_pos, 24'd0);
      scanner_reset();
    end else begin
      case (sc_mode)
        M_COMMENT: if (c == 8'h0a) begin
          bump_line();
          sc_mode = M_IDLE;
        end
        M_SLASH: if (c == "/") sc_mode = M_COMMENT;
          else begin
            push_token(K_SLASH, E_NONE, sc_start, 24'd1);
            fresh = 1;
          end
        M_EQ: if (c == ">") begin
            push_token(K_ARROW, E_NONE, sc_start, span(sc_start, {1'b0, sc_pos} + 25'd1));
            sc_mode = M_IDLE;
          end else begin
            push_token(K_ASSIGN, E_NONE, sc_start, 24'd1);
            fresh = 1;
          end
        M_QUEST, M_BANG, M_LESS, M_GREATER: if (c == "=") begin
            push_token(single_op(sc_mode) - 5'd1, E_NONE, sc_start,
                       span(sc_start, {1'b0, sc_pos} + 25'd1));
            sc_mode = M_IDLE;
          end else begin
            push_token(single_op(sc_mode), E_NONE, sc_start, 24'd1);
            fresh = 1;
          end
        M_IDENT: if (alpha_c(c) || digit_c(c)) begin
            if (span(sc_start, {1'b0, sc_pos}) < 5) sc_prefix = {sc_prefix[31:0], c};
            else sc_prefix = '0;
          end else begin
            name_token();
            fresh = 1;
          end
        M_INT: if (c == ".") sc_mode = M_DOT;
          else if (!digit_c(c)) begin
            push_token(K_NUMBER, E_NONE, sc_start, span(sc_start, {1'b0, sc_pos}));
            fresh = 1;
          end
        M_DOT: if (digit_c(c)) sc_mode = M_FRAC;
          else begin
            number_dot_tokens();
            fresh = 1;
          end
        M_FRAC: if (!digit_c(c)) begin
            push_token(K_NUMBER, E_NONE, sc_start, span(sc_start, {1'b0, sc_pos}));
            fresh = 1;
          end
        M_STR: string_char(c);
        M_STR_ESC: if (c == 8'h5c || c == 8'h27 || c == 8'h0d || c == 8'h0a || c == 8'h09)
            sc_mode = M_STR;
          else string_char(c);
        default: fresh = 1;
      endcase
      if (fresh) begin_token(c);
      if (sc_pos != 24'hFFFFFF) sc_pos++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  // stimulus helpers
  task automatic add_byte(logic [7:0] c);
    pending_beats.push_back('{byte_val: c, fin: 1'b0});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_end(bit use_zero);
    if (use_zero) pending_beats.push_back('{byte_val: 8'h00, fin: 1'b0});
    else pending_beats.push_back('{byte_val: 8'($urandom), fin: 1'b1});
  endtask

  function automatic string random_lexeme();
    string pool[] = '{"and", "if", "or", "while", "false", "true", "x", "abc_9", "andy",
                      "whiles", "Zq_", "0", "42", "3.14", "7.", "12.x", "//c\n", "'ab'",
                      "'a\\'b'", "'\\n\\\n'", "'\\q'", "=>", "?=", "!=", "<=", ">=", "=",
                      "?", "!", "<", ">", "/", "(", ")", ",", ".", "%", "+", "-", "*",
                      "^", ":", " ", "\t", "\r", "\n", "@", "#", "'open"};
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      byte_in.valid <= 1'b0;
      byte_in.source_byte <= 8'h00;
      byte_in.end_of_source <= 1'b0;
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        predict_tokens('{byte_val: byte_in.source_byte, fin: byte_in.end_of_source});
        byte_count++;
      end
      if (!byte_in.valid || byte_in.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          byte_in.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          src_beat_t b;
          b = pending_beats.pop_front();
          byte_in.valid <= 1'b1;
          byte_in.source_byte <= b.byte_val;
          byte_in.end_of_source <= b.fin;
          src_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        end else begin
          byte_in.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int snk_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      token_out.ready <= 1'b0;
    end else begin
      if (token_out.valid && token_out.ready) begin
        token_t got, want;
        got = '{kind: token_out.token_kind, err: token_out.error_kind,
                off: token_out.token_offset, len: token_out.token_length,
                line: token_out.line_number, last: token_out.last_of_run};
        token_count++;
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token %p", got);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("token mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (hold_sink) begin
        token_out.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        token_out.ready <= 1'b0;
      end else begin
        token_out.ready <= 1'b1;
        if (token_out.valid) snk_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout with %0d tokens outstanding", expected_tokens.size());
      $display("source_text_tokenizer_top_test: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() > 0 || byte_in.valid || expected_tokens.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    byte_in.valid = 1'b0;
    byte_in.source_byte = 8'h00;
    byte_in.end_of_source = 1'b0;
    token_out.ready = 1'b0;
    scanner_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: keywords, numbers, operators, escapes, stray bytes, both end forms
    add_text("and if or while false true _id9 1.5 7.a 3 'x\\'\\\n' =>?=!=<=>= // c\n");
    add_text("()");
    add_byte(8'hFF);
    add_byte(8'h80);
    add_end(1'b1);
    add_text("=?!<>/.'\\zab");
    add_end(1'b0);
    wait_drained();

    // hold the sink off while bytes keep coming so the token queue fills
    hold_sink = 1;
    repeat (40) add_text("+-*");
    repeat (200) @(posedge clk);
    hold_sink = 0;
    wait_drained();

    // random: mostly well-formed lexemes, some raw noise
    for (int n = 0; n < 165; ) begin
      if ($urandom_range(9) == 0) begin
        add_byte(8'($urandom_range(1, 255)));
        n++;
      end else if ($urandom_range(30) == 0) begin
        add_end($urandom_range(1));
        n++;
      end else begin
        string s;
        s = random_lexeme();
        add_text(s);
        n += s.len();
      end
    end
    add_end(1'b0);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("drove %0d source bytes and checked %0d tokens, %0d mismatches",
             byte_count, token_count, mismatches);
    if (mismatches == 0 && expected_tokens.size() == 0)
      $display("source_text_tokenizer_top_test: clean");
    else
      $display("source_text_tokenizer_top_test: errors");
    $finish;
  end

endmodule

### files.f
src/stt_pkg.sv
src/stt_in_if.sv
src/stt_out_if.sv
src/source_text_tokenizer_top.sv
verif/source_text_tokenizer_top_test.sv
